FILE: rtl/core/sacnlp_pkg.sv
// shared constants and types for the set-associative cache with prefetch
package sacnlp_pkg;

  localparam int unsigned MAX_SETS_DEF  = 64;
  localparam int unsigned WAYS_DEF      = 8;
  localparam int unsigned ADDR_BITS_DEF = 48;

  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned STAMP_W       = 32;
  localparam int unsigned CNT_W         = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LRU     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFETCH_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE     = 3'd4;

  // configuration as seen by the lookup engine
  typedef struct packed {
    logic       replace_lru;
    logic       prefetch_enable;
    logic [2:0] set_bits;
    logic [3:0] block_bits;
    logic [3:0] ways_in_use;
  } cfg_t;

endpackage

FILE: rtl/core/set_assoc_cache_with_next_line_prefetch_unit.sv
// Set-associative write-through tag store with FIFO or LRU replacement and
// next-line prefetch. After reset the set memory is cleared one set per cycle,
// so the input stalls until the clearing pass is done. One word is handled at
// a time: a demand lookup goes through accept, set row read, evaluate and write
// back, and result, and a miss with prefetch enabled repeats the row read and
// evaluate steps for the next line. Results wait in the output until taken.
module set_assoc_cache_with_next_line_prefetch_unit
  import sacnlp_pkg::*;
#(
  parameter int unsigned MAX_SETS  = MAX_SETS_DEF,
  parameter int unsigned WAYS      = WAYS_DEF,
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [3:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [ADDR_BITS-1:0] in_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic [CNT_W-1:0]     out_memory_reads,
  output logic [CNT_W-1:0]     out_memory_writes,
  output logic [CNT_W-1:0]     out_hit_total,
  output logic [CNT_W-1:0]     out_miss_total
);

  cfg_t cfg;
  logic rdy;

  assign cfg_ready = 1'b1;

  sacnlp_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .wr_en(cfg_valid), .wr_index(cfg_index),
    .wr_data(cfg_data), .cfg(cfg)
  );

  sacnlp_engine #(.MAX_SETS(MAX_SETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS)) u_eng (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .req_valid(in_valid), .req_ready(rdy), .req_cmd(in_cmd), .req_addr(in_address),
    .res_valid(out_valid), .res_ready(!out_stall), .res_hit(out_hit),
    .res_reads(out_memory_reads), .res_writes(out_memory_writes),
    .res_hits(out_hit_total), .res_misses(out_miss_total)
  );

  assign in_stall = !rdy;

endmodule

FILE: rtl/core/sacnlp_cfg_regs.sv
// configuration register file
module sacnlp_cfg_regs
  import sacnlp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [3:0]           wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.replace_lru     <= 1'b0;
      cfg_r.prefetch_enable <= 1'b0;
      cfg_r.set_bits        <= 3'd0;
      cfg_r.block_bits      <= 4'd6;
      cfg_r.ways_in_use     <= 4'd1;
    end else if (wr_en) begin
      case (wr_index)
        REG_REPLACE_LRU:     cfg_r.replace_lru     <= wr_data[0];
        REG_PREFETCH_ENABLE: cfg_r.prefetch_enable <= wr_data[0];
        REG_SET_BITS:        cfg_r.set_bits        <= wr_data[2:0];
        REG_BLOCK_BITS:      cfg_r.block_bits      <= wr_data;
        REG_WAYS_IN_USE:     cfg_r.ways_in_use     <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/sacnlp_engine.sv
// set memory and the lookup sequencer
module sacnlp_engine
  import sacnlp_pkg::*;
#(
  parameter int unsigned MAX_SETS  = MAX_SETS_DEF,
  parameter int unsigned WAYS      = WAYS_DEF,
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic                 req_cmd,
  input  logic [ADDR_BITS-1:0] req_addr,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic                 res_hit,
  output logic [CNT_W-1:0]     res_reads,
  output logic [CNT_W-1:0]     res_writes,
  output logic [CNT_W-1:0]     res_hits,
  output logic [CNT_W-1:0]     res_misses
);

  localparam int unsigned SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WCNT_W  = $clog2(WAYS + 1);
  localparam int unsigned VLD_OFS = ADDR_BITS + STAMP_W;
  localparam int unsigned ENTRY_W = ADDR_BITS + STAMP_W + 1;
  localparam int unsigned ROW_W   = WAYS * ENTRY_W;
  // largest set_bits with 2^set_bits <= MAX_SETS
  localparam int unsigned MAXSB   = $clog2(MAX_SETS + 1) - 1;
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

  typedef enum logic [4:0] {
    ST_CLR   = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // one row per set: valid, stamp and tag of every way
  logic [ROW_W-1:0] mem [MAX_SETS];
  logic [ROW_W-1:0] rd_row_r;
  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic [SET_W-1:0] mem_raddr;

  logic [SET_W-1:0] clr_r;

  logic [ADDR_BITS-1:0] addr_r;
  logic                 cmd_r;
  logic                 pf_r;        // prefetch lookup in flight
  logic                 hit_r;
  logic [STAMP_W-1:0]   stamp_r;
  logic [CNT_W-1:0]     reads_r, writes_r, hits_r, misses_r;

  // effective configuration
  logic [2:0]          sb;
  logic [WCNT_W-1:0]   nways;
  always_comb begin
    sb = cfg.set_bits;
    if ({29'd0, sb} > MAXSB[31:0]) sb = MAXSB[2:0];
    if (cfg.ways_in_use == 4'd0) nways = WCNT_W'(1);
    else if ({28'd0, cfg.ways_in_use} > WAYS) nways = WCNT_W'(WAYS);
    else nways = WCNT_W'(cfg.ways_in_use);
  end

  // address split
  logic [ADDR_BITS-1:0] shifted;
  logic [SET_W-1:0]     set_idx;
  logic [ADDR_BITS-1:0] tag;
  always_comb begin
    shifted = addr_r >> cfg.block_bits;
    set_idx = SET_W'(shifted & ADDR_BITS'((64'd1 << sb) - 64'd1));
    tag     = shifted >> sb;
  end

  // way scan over the read row
  logic [STAMP_W-1:0] stamp_inc;
  logic               f_hit, f_fill;
  logic [WAY_W-1:0]   f_way, v_way;
  logic [STAMP_W-1:0] v_stamp;
  logic               done;
  always_comb begin
    done  = 1'b0;
    f_hit = 1'b0;
    f_fill = 1'b0;
    f_way = '0;
    v_way = '0;
    v_stamp = rd_row_r[ADDR_BITS +: STAMP_W];
    stamp_inc = stamp_r + STAMP_W'(1);
    for (int i = 0; i < WAYS; i++) begin
      if (!done && WCNT_W'(i) < nways) begin
        if (!rd_row_r[i*ENTRY_W + VLD_OFS]) begin
          f_fill = 1'b1; f_way = WAY_W'(i); done = 1'b1;
        end else if (rd_row_r[i*ENTRY_W +: ADDR_BITS] == tag) begin
          f_hit = 1'b1; f_way = WAY_W'(i); done = 1'b1;
        end
      end
      if (i > 0 && WCNT_W'(i) < nways &&
          rd_row_r[i*ENTRY_W + ADDR_BITS +: STAMP_W] < v_stamp) begin
        v_stamp = rd_row_r[i*ENTRY_W + ADDR_BITS +: STAMP_W];
        v_way   = WAY_W'(i);
      end
    end
  end

  logic [WAY_W-1:0] w_way;
  logic             do_write;
  logic             refresh;
  always_comb begin
    refresh  = f_hit && cfg.replace_lru && !pf_r;
    do_write = !f_hit || refresh;
    w_way    = (f_hit || f_fill) ? f_way : v_way;
    mem_wdata = rd_row_r;
    mem_wdata[w_way*ENTRY_W +: ENTRY_W] =
      {1'b1, stamp_inc, f_hit ? rd_row_r[w_way*ENTRY_W +: ADDR_BITS] : tag};
    mem_we    = (state_r == ST_EVAL) && do_write;
    mem_waddr = set_idx;
    mem_raddr = set_idx;
    // clearing pass after reset, one set per cycle
    if (state_r == ST_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_row_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR: if (clr_r == LAST_SET) state_nxt = ST_IDLE;
      ST_IDLE: if (req_valid) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (!pf_r && !f_hit && cfg.prefetch_enable) state_nxt = ST_READ;
        else state_nxt = ST_OUT;
      end
      ST_OUT: if (res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      clr_r    <= '0;
      stamp_r  <= '0;
      reads_r  <= '0;
      writes_r <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      pf_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_CLR: clr_r <= clr_r + SET_W'(1);
        ST_IDLE: if (req_valid) begin
          addr_r <= req_addr;
          cmd_r  <= req_cmd;
          pf_r   <= 1'b0;
        end
        ST_EVAL: begin
          if (do_write) stamp_r <= stamp_inc;
          if (!pf_r) begin
            hit_r <= f_hit;
            if (cmd_r) writes_r <= writes_r + CNT_W'(1);
            if (f_hit) hits_r <= hits_r + CNT_W'(1);
            else begin
              misses_r <= misses_r + CNT_W'(1);
              reads_r  <= reads_r + CNT_W'(1);
              if (cfg.prefetch_enable) begin
                pf_r   <= 1'b1;
                addr_r <= addr_r + ADDR_BITS'(64'd1 << cfg.block_bits);
              end
            end
          end else if (!f_hit) begin
            reads_r <= reads_r + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign req_ready  = (state_r == ST_IDLE);
  assign res_valid  = (state_r == ST_OUT);
  assign res_hit    = hit_r;
  assign res_reads  = reads_r;
  assign res_writes = writes_r;
  assign res_hits   = hits_r;
  assign res_misses = misses_r;

endmodule
